### hdl/assert_macros.svh
// Assertion macros shared by the RTL of the UTF-8 stream decoder.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/u8d_pkg.sv
// Shared widths, lead-byte thresholds, masks and payload types of the
// UTF-8 stream decoder. No dependencies.
package u8d_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned CP_W      = 31;
    localparam int unsigned REM_W     = 3;
    localparam int unsigned CONT_BITS = 6;

    // Lead-byte thresholds: a byte below each bound opens a shorter sequence.
    localparam logic [BYTE_W-1:0] C_LEAD2_MIN = 8'hC0;
    localparam logic [BYTE_W-1:0] C_LEAD3_MIN = 8'hE0;
    localparam logic [BYTE_W-1:0] C_LEAD4_MIN = 8'hF0;
    localparam logic [BYTE_W-1:0] C_LEAD5_MIN = 8'hF8;
    localparam logic [BYTE_W-1:0] C_LEAD6_MIN = 8'hFC;

    // Payload masks for lead bytes of each length.
    localparam logic [BYTE_W-1:0] M_LEAD2 = 8'h1F;
    localparam logic [BYTE_W-1:0] M_LEAD3 = 8'h0F;
    localparam logic [BYTE_W-1:0] M_LEAD4 = 8'h07;
    localparam logic [BYTE_W-1:0] M_LEAD5 = 8'h03;
    localparam logic [BYTE_W-1:0] M_LEAD6 = 8'h01;

    // Continuation bytes still expected after each lead length.
    localparam logic [REM_W-1:0] REM_LEAD2 = 3'd1;
    localparam logic [REM_W-1:0] REM_LEAD3 = 3'd2;
    localparam logic [REM_W-1:0] REM_LEAD4 = 3'd3;
    localparam logic [REM_W-1:0] REM_LEAD5 = 3'd4;
    localparam logic [REM_W-1:0] REM_LEAD6 = 3'd5;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              end_of_string;
    } t_in_item;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            error;
        logic            last;
    } t_out_item;

    typedef struct packed {
        logic fire;   // decoder consumed a byte this cycle
        logic busy;   // inside a multi-byte sequence
    } t_dec_status;

endpackage

### hdl/u8d_in_if.sv
// Byte channel of the UTF-8 stream decoder: valid/ready plus one byte
// and its end-of-string flag. Depends on u8d_pkg.
interface u8d_in_if;
    import u8d_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_string;

    modport source (output valid, output data_byte, output end_of_string, input ready);
    modport sink   (input valid, input data_byte, input end_of_string, output ready);
endinterface

### hdl/u8d_out_if.sv
// Code-point channel of the UTF-8 stream decoder: valid/ready plus the
// code point, error and last flags. Depends on u8d_pkg.
interface u8d_out_if;
    import u8d_pkg::*;

    logic            valid;
    logic            ready;
    logic [CP_W-1:0] code_point;
    logic            error;
    logic            last;

    modport source (output valid, output code_point, output error, output last, input ready);
    modport sink   (input valid, input code_point, input error, input last, output ready);
endinterface

### hdl/u8d_in_stage.sv
// Input register of the UTF-8 stream decoder: captures one byte transfer.
// Depends on u8d_pkg and u8d_in_if.
module u8d_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    u8d_in_if.sink            i_in,
    input  logic              i_advance,
    output logic              o_valid,
    output u8d_pkg::t_in_item o_item
);
    import u8d_pkg::*;

    logic     r_valid;
    logic     n_valid;
    t_in_item r_item;

    assign i_in.ready = !r_valid || i_advance;
    assign n_valid    = i_in.ready ? i_in.valid : r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_item <= '{data_byte: i_in.data_byte, end_of_string: i_in.end_of_string};
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
endmodule

### hdl/u8d_decode.sv
// Sequence decoder: holds the pending length and partial code point and
// turns one registered byte into at most one result. Depends on u8d_pkg.
module u8d_decode (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  u8d_pkg::t_in_item    i_item,
    input  logic                 i_out_free,
    output logic                 o_advance,
    output logic                 o_res_valid,
    output u8d_pkg::t_out_item   o_res,
    output u8d_pkg::t_dec_status o_status
);
    import u8d_pkg::*;

    logic [REM_W-1:0]  r_rem;
    logic [REM_W-1:0]  n_rem;
    logic [CP_W-1:0]   r_partial;
    logic [CP_W-1:0]   n_partial;
    logic [CP_W-1:0]   shifted;
    logic [CP_W-1:0]   cp;
    logic [BYTE_W-1:0] b;
    logic              done;
    logic              eos;
    logic              fire;

    assign b       = i_item.data_byte;
    assign eos     = i_item.end_of_string;
    assign fire    = i_valid && i_out_free;
    assign shifted = {r_partial[CP_W-CONT_BITS-1:0], b[CONT_BITS-1:0]};

    always_comb begin
        n_rem     = r_rem;
        n_partial = r_partial;
        done      = 1'b0;
        cp        = '0;
        if (r_rem == '0) begin
            if (b < C_LEAD2_MIN) begin
                cp   = CP_W'(b);
                done = 1'b1;
            end else if (b < C_LEAD3_MIN) begin
                n_partial = CP_W'(b & M_LEAD2);
                n_rem     = REM_LEAD2;
            end else if (b < C_LEAD4_MIN) begin
                n_partial = CP_W'(b & M_LEAD3);
                n_rem     = REM_LEAD3;
            end else if (b < C_LEAD5_MIN) begin
                n_partial = CP_W'(b & M_LEAD4);
                n_rem     = REM_LEAD4;
            end else if (b < C_LEAD6_MIN) begin
                n_partial = CP_W'(b & M_LEAD5);
                n_rem     = REM_LEAD5;
            end else begin
                n_partial = CP_W'(b & M_LEAD6);
                n_rem     = REM_LEAD6;
            end
        end else begin
            // any byte here counts as continuation, low six bits only
            n_partial = shifted;
            n_rem     = r_rem - REM_W'(1);
            if (r_rem == REM_W'(1)) begin
                cp   = shifted;
                done = 1'b1;
            end
        end
        if (eos) begin
            n_rem     = '0;
            n_partial = '0;
        end else if (done) begin
            n_partial = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem     <= '0;
            r_partial <= '0;
        end else if (fire) begin
            r_rem     <= n_rem;
            r_partial <= n_partial;
        end
    end

    assign o_advance   = i_out_free;
    assign o_res_valid = fire && (done || eos);
    assign o_res       = '{code_point: (done ? cp : '0), error: (eos && !done), last: eos};
    assign o_status    = '{fire: fire, busy: (r_rem != '0)};
endmodule

### hdl/u8d_out_stage.sv
// Result register of the UTF-8 stream decoder: holds one code-point
// transfer until taken. Depends on u8d_pkg and u8d_out_if.
module u8d_out_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  u8d_pkg::t_out_item i_res,
    u8d_out_if.source          o_out,
    output logic               o_free
);
    import u8d_pkg::*;

    logic      r_valid;
    logic      n_valid;
    t_out_item r_res;

    assign o_free  = !r_valid || o_out.ready;
    assign n_valid = o_free ? i_load : r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_res <= i_res;
        end
    end

    assign o_out.valid      = r_valid;
    assign o_out.code_point = r_res.code_point;
    assign o_out.error      = r_res.error;
    assign o_out.last       = r_res.last;
endmodule

### hdl/utf8_stream_decoder_unit.sv
// Top level of the UTF-8 stream decoder: input register, sequence decoder
// and result register. Depends on u8d_pkg, u8d_in_if, u8d_out_if, assert_macros.svh.
//
//   channel | dir | payload                          | role
//   i_in    | in  | data_byte[7:0], end_of_string    | one byte of the encoded string
//   o_out   | out | code_point[30:0], error, last    | decoded code point or error
//
// Takes one byte per clock while o_out is not stalled; a byte is held in the
// input register, and its result is then held in the result register.
// Reset (i_rst_n low, synchronous) empties both registers and clears the
// sequence state. A stall on o_out holds the result register, then the
// input register, and only then drops i_in.ready; no transfer is lost.
`include "assert_macros.svh"

module utf8_stream_decoder_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    u8d_in_if.sink    i_in,
    u8d_out_if.source o_out
);
    import u8d_pkg::*;

    logic        w_in_valid;
    t_in_item    w_in_item;
    logic        w_advance;
    logic        w_out_free;
    logic        w_res_valid;
    t_out_item   w_res;
    t_dec_status w_status;
    logic        w_err_out;
    logic        w_eos_taken;

    // Capture the byte transfer; advance whenever the decoder can move on.
    u8d_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_advance (w_advance),
        .o_valid   (w_in_valid),
        .o_item    (w_in_item)
    );

    // Decode the held byte against the pending sequence state.
    u8d_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_in_valid),
        .i_item      (w_in_item),
        .i_out_free  (w_out_free),
        .o_advance   (w_advance),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .o_status    (w_status)
    );

    // Hold the result until the sink takes it.
    u8d_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_res_valid),
        .i_res   (w_res),
        .o_out   (o_out),
        .o_free  (w_out_free)
    );

    assign w_err_out   = o_out.valid && o_out.error;
    assign w_eos_taken = w_status.fire && w_in_item.end_of_string;

    // An error only closes a string.
    `ASSERT_IMPL(a_err_is_last, w_err_out, o_out.last, "error result without last")
    // An error carries no code point.
    `ASSERT_IMPL(a_err_zero_cp, w_err_out, o_out.code_point == '0, "error with code point")
    // The end of a string leaves no sequence pending.
    `ASSERT_NEXT(a_eos_clears, w_eos_taken, !w_status.busy, "state kept past end of string")
endmodule

### bench/tb_utf8_stream_decoder_unit.sv
// Self-checking testbench for utf8_stream_decoder_unit: directed and random byte strings,
// with a scoreboard that decodes each accepted byte and checks every code point.
// Depends on u8d_pkg, u8d_in_if, u8d_out_if and the decoder RTL.
`timescale 1ns / 1ps

module tb_utf8_stream_decoder_unit;
    import u8d_pkg::*;

    localparam int unsigned RANDOM_BYTES = 1750;
    localparam int unsigned QUIET_LIMIT  = 4000;  // cycles without any transfer
    localparam int unsigned HOLD_CYCLES  = 240;   // long result-side hold-off
    localparam int unsigned TAIL_CYCLES  = 8;     // idle time after the final drain
    localparam int unsigned MAX_REPORTS  = 10;

    // Shadow decoder plus the queue of code points still to come out.
    class code_point_scoreboard;
        logic [REM_W-1:0] cont_left;
        logic [CP_W-1:0]  code_acc;
        t_out_item        pending_code_points[$];
        int unsigned      mismatches;
        int unsigned      results_seen;

        function new();
            cont_left    = '0;
            code_acc     = '0;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        // Decode one accepted byte and queue the result it causes, if any.
        function void note_byte(t_in_item it);
            logic [CP_W-1:0] cp;
            logic            done;
            t_out_item       exp;
            cp   = '0;
            done = 1'b0;
            if (cont_left == '0) begin
                if (it.data_byte < C_LEAD2_MIN) begin
                    // plain byte, stray continuation bytes included
                    cp   = {{(CP_W-BYTE_W){1'b0}}, it.data_byte};
                    done = 1'b1;
                end else if (it.data_byte < C_LEAD3_MIN) begin
                    code_acc  = {{(CP_W-BYTE_W){1'b0}}, it.data_byte & M_LEAD2};
                    cont_left = REM_LEAD2;
                end else if (it.data_byte < C_LEAD4_MIN) begin
                    code_acc  = {{(CP_W-BYTE_W){1'b0}}, it.data_byte & M_LEAD3};
                    cont_left = REM_LEAD3;
                end else if (it.data_byte < C_LEAD5_MIN) begin
                    code_acc  = {{(CP_W-BYTE_W){1'b0}}, it.data_byte & M_LEAD4};
                    cont_left = REM_LEAD4;
                end else if (it.data_byte < C_LEAD6_MIN) begin
                    code_acc  = {{(CP_W-BYTE_W){1'b0}}, it.data_byte & M_LEAD5};
                    cont_left = REM_LEAD5;
                end else begin
                    code_acc  = {{(CP_W-BYTE_W){1'b0}}, it.data_byte & M_LEAD6};
                    cont_left = REM_LEAD6;
                end
            end else begin
                // any byte inside a sequence counts as continuation, unchecked
                code_acc  = {code_acc[CP_W-CONT_BITS-1:0], it.data_byte[CONT_BITS-1:0]};
                cont_left = cont_left - 1'b1;
                if (cont_left == '0) begin
                    cp   = code_acc;
                    done = 1'b1;
                end
            end

            if (it.end_of_string) begin
                exp.code_point = done ? cp : '0;
                exp.error      = ~done;
                exp.last       = 1'b1;
                pending_code_points = {pending_code_points, exp};
                cont_left = '0;
                code_acc  = '0;
            end else if (done) begin
                exp.code_point = cp;
                exp.error      = 1'b0;
                exp.last       = 1'b0;
                pending_code_points = {pending_code_points, exp};
                code_acc = '0;
            end
        endfunction

        function void flag(string what);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("[%0t] %s", $time, what);
        endfunction

        // Compare one accepted result with the oldest expectation.
        function void check_code_point(t_out_item got);
            t_out_item exp;
            results_seen++;
            if (pending_code_points.size() == 0) begin
                flag($sformatf("result %0d unexpected: cp=%h err=%b last=%b",
                               results_seen, got.code_point, got.error, got.last));
                return;
            end
            exp = pending_code_points.pop_front();
            if (got.code_point !== exp.code_point || got.error !== exp.error ||
                got.last !== exp.last)
                flag($sformatf("result %0d: exp cp=%h err=%b last=%b got cp=%h err=%b last=%b",
                               results_seen, exp.code_point, exp.error, exp.last,
                               got.code_point, got.error, got.last));
        endfunction

        function int unsigned outstanding();
            return pending_code_points.size();
        endfunction

        function void flag_leftovers();
            if (pending_code_points.size() != 0)
                flag($sformatf("%0d results never arrived", pending_code_points.size()));
        endfunction
    endclass

    typedef enum logic [1:0] {
        RX_OPEN,     // ready except during a hold
        RX_SPARSE,   // stalls now and then
        RX_DENSE,    // mostly stalled
        RX_COMB      // fixed periodic pattern
    } t_rx_mode;

    logic i_clk;
    logic i_rst_n;

    u8d_in_if  byte_ch ();
    u8d_out_if cp_ch ();

    utf8_stream_decoder_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_ch),
        .o_out   (cp_ch)
    );

    code_point_scoreboard sb;
    bit                   hold_request;
    int unsigned          bytes_sent;
    int unsigned          burst_left;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Result side: check each transfer, then pick ready for the next cycle.
    // A hold request from the stimulus keeps ready low for a long stretch.
    initial begin : result_sink
        t_out_item   got;
        t_rx_mode    mode;
        int unsigned mode_left;
        int unsigned hold_left;
        mode      = RX_OPEN;
        mode_left = 0;
        hold_left = 0;
        cp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && cp_ch.valid && cp_ch.ready) begin
                got.code_point = cp_ch.code_point;
                got.error      = cp_ch.error;
                got.last       = cp_ch.last;
                sb.check_code_point(got);
            end
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (mode_left == 0) begin
                mode      = t_rx_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            if (hold_left != 0) begin
                hold_left--;
                cp_ch.ready <= 1'b0;
            end else begin
                case (mode)
                    RX_OPEN:   cp_ch.ready <= 1'b1;
                    RX_SPARSE: cp_ch.ready <= ($urandom_range(0, 3) != 0);
                    RX_DENSE:  cp_ch.ready <= ($urandom_range(0, 3) == 0);
                    default:   cp_ch.ready <= ((mode_left % 5) >= 2);
                endcase
            end
        end
    end

    // End the run if no transfer happens on either channel for too long.
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((byte_ch.valid && byte_ch.ready) || (cp_ch.valid && cp_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // Offer one byte and hold it until the transfer; bursts of random length
    // are separated by random gaps, some bursts run back to back.
    task automatic push_byte(input logic [BYTE_W-1:0] b, input logic eos);
        t_in_item    it;
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                byte_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 48);
        end
        burst_left--;
        it.data_byte     = b;
        it.end_of_string = eos;
        byte_ch.valid         <= 1'b1;
        byte_ch.data_byte     <= b;
        byte_ch.end_of_string <= eos;
        do @(posedge i_clk); while (!(byte_ch.valid && byte_ch.ready));
        sb.note_byte(it);
        bytes_sent++;
    endtask

    // Stop offering and wait until every queued result has come out.
    task automatic drain_results();
        byte_ch.valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
    endtask

    // Pick a lead byte for a sequence of the given length.
    function automatic logic [BYTE_W-1:0] lead_for(int unsigned len);
        case (len)
            1:       return BYTE_W'($urandom_range(0, 8'hBF));
            2:       return BYTE_W'($urandom_range(C_LEAD2_MIN, C_LEAD3_MIN - 1));
            3:       return BYTE_W'($urandom_range(C_LEAD3_MIN, C_LEAD4_MIN - 1));
            4:       return BYTE_W'($urandom_range(C_LEAD4_MIN, C_LEAD5_MIN - 1));
            5:       return BYTE_W'($urandom_range(C_LEAD5_MIN, C_LEAD6_MIN - 1));
            default: return BYTE_W'($urandom_range(C_LEAD6_MIN, 8'hFF));
        endcase
    endfunction

    // One string of well-formed characters with random content; some strings
    // end inside a sequence, some characters are raw noise bytes, and some
    // continuation bytes are arbitrary.
    task automatic send_random_string();
        int unsigned      n_chars;
        int unsigned      len;
        int unsigned      count;
        int unsigned      pick;
        bit               truncate;
        bit               last_char;
        logic [BYTE_W-1:0] b;
        n_chars  = $urandom_range(1, 12);
        truncate = ($urandom_range(0, 5) == 0);
        for (int unsigned c = 0; c < n_chars; c++) begin
            pick = $urandom_range(0, 15);
            if (pick <= 5)       len = 1;
            else if (pick <= 8)  len = 2;
            else if (pick <= 10) len = 3;
            else if (pick <= 12) len = 4;
            else if (pick == 13) len = 5;
            else                 len = 6;
            last_char = (c == n_chars - 1);
            count = len;
            if (last_char && truncate && len > 1)
                count = $urandom_range(1, len - 1);
            for (int unsigned k = 0; k < count; k++) begin
                if (k == 0)
                    b = (pick == 15) ? BYTE_W'($urandom_range(0, 255)) : lead_for(len);
                else if ($urandom_range(0, 9) == 0)
                    b = BYTE_W'($urandom_range(0, 255));
                else
                    b = BYTE_W'($urandom_range(8'h80, 8'hBF));
                // a noise lead may open a sequence; the bytes that follow close it
                push_byte(b, last_char && (k == count - 1));
            end
        end
    endtask

    initial begin : stimulus
        bit held;
        bit paused;
        sb           = new();
        hold_request = 1'b0;
        bytes_sent   = 0;
        burst_left   = 0;
        held         = 1'b0;
        paused       = 1'b0;

        i_rst_n               <= 1'b0;
        byte_ch.valid         <= 1'b0;
        byte_ch.data_byte     <= '0;
        byte_ch.end_of_string <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: plain bytes and stray continuations pass through.
        push_byte(8'h00, 1'b0);
        push_byte(8'hBF, 1'b0);
        push_byte(8'h7F, 1'b1);
        // Two-byte sequences; an ASCII byte is taken as continuation.
        push_byte(8'hC0, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hDF, 1'b0);
        push_byte(8'hFF, 1'b0);
        // Three- and four-byte sequences at both extremes.
        push_byte(8'hE0, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'hF7, 1'b0);
        push_byte(8'hBF, 1'b0);
        push_byte(8'hBF, 1'b0);
        push_byte(8'hBF, 1'b0);
        // Six-byte sequence giving the largest code point, completed at the end.
        push_byte(8'hFD, 1'b0);
        push_byte(8'hBF, 1'b0);
        push_byte(8'hBF, 1'b0);
        push_byte(8'hBF, 1'b0);
        push_byte(8'hBF, 1'b0);
        push_byte(8'hBF, 1'b1);
        // Strings that end inside a five- and a six-byte sequence.
        push_byte(8'hF8, 1'b0);
        push_byte(8'h80, 1'b1);
        push_byte(8'hFC, 1'b1);
        // State must be clear again after the error.
        push_byte(8'h41, 1'b1);
        drain_results();

        while (bytes_sent < RANDOM_BYTES) begin
            send_random_string();
            // Hold off the result side while bytes keep coming, so the
            // decoder fills and drops its input ready.
            if (!held && bytes_sent >= 600) begin
                held         = 1'b1;
                hold_request = 1'b1;
            end
            if (!paused && bytes_sent >= 1100) begin
                paused = 1'b1;
                drain_results();
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        sb.flag_leftovers();
        if (sb.mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
